// ===== rtl/core/crc8wd_pkg.sv =====
package crc8wd_pkg;

  localparam int unsigned WordBytes = 2;
  localparam int unsigned PosW      = $clog2(WordBytes + 1);
  localparam int unsigned WordW     = 16;

  localparam logic [7:0] CrcPolyReset = 8'h31;
  localparam logic [7:0] CrcInitReset = 8'hFF;
  localparam logic [7:0] CrcTopBit    = 8'h80;

  // register indexes on the config port
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgCrcPoly = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCrcInit = 1'b1;

  // word_status codes
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusMismatch  = 2'd1;
  localparam logic [1:0] StatusTruncated = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] data_word;
    logic [1:0]       word_status;
    logic             end_of_transfer;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    out_item_t  item;
  } res_t;

  typedef struct packed {
    logic [7:0] poly;
    logic [7:0] init;
  } cfg_t;

  // MSB-first CRC-8 update over one byte, unrolled
  function automatic logic [7:0] crc_feed(input logic [7:0] crc,
                                          input logic [7:0] data,
                                          input logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((v & CrcTopBit) != 8'h00) begin
        v = {v[6:0], 1'b0} ^ poly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/crc8wd_in_stage.sv =====
module crc8wd_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  crc8wd_pkg::in_item_t in_item_i,
  input  logic                adv_i,
  output logic                item_valid_o,
  output crc8wd_pkg::in_item_t item_o
);
  import crc8wd_pkg::*;

  logic     valid_q;
  in_item_t item_q;
  logic     accept;

  // a held item blocks only when the next stage cannot take it this cycle
  assign in_stall_o = valid_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/core/crc8wd_frame_ctl.sv =====
module crc8wd_frame_ctl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  crc8wd_pkg::in_item_t item_i,
  input  crc8wd_pkg::cfg_t     cfg_i,
  output crc8wd_pkg::res_t     res_o
);
  import crc8wd_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       crc_q, crc_d;
  logic [WordW-1:0] word_q, word_d;
  logic             abort_q, abort_d;

  logic [7:0] seed;
  logic       crc_match;

  assign seed      = (pos_q == '0) ? cfg_i.init : crc_q;
  assign crc_match = (crc_q == item_i.rx_byte);

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    word_d  = word_q;
    abort_d = abort_q;
    res_o   = '0;
    if (fire_i) begin
      if (abort_q) begin
        // discard until the last byte of the transfer
        if (item_i.last_byte) begin
          abort_d = 1'b0;
          pos_d   = '0;
          word_d  = '0;
        end
      end else if (pos_q < PosW'(WordBytes)) begin
        crc_d  = crc_feed(seed, item_i.rx_byte, cfg_i.poly);
        word_d = {word_q[WordW-9:0], item_i.rx_byte};
        pos_d  = pos_q + PosW'(1);
        if (item_i.last_byte) begin
          res_o.valid                = 1'b1;
          res_o.item.data_word       = '0;
          res_o.item.word_status     = StatusTruncated;
          res_o.item.end_of_transfer = 1'b1;
          pos_d                      = '0;
          word_d                     = '0;
        end
      end else begin
        // check byte
        res_o.valid          = 1'b1;
        res_o.item.data_word = word_q;
        if (crc_match) begin
          res_o.item.word_status     = StatusOk;
          res_o.item.end_of_transfer = item_i.last_byte;
        end else begin
          res_o.item.word_status     = StatusMismatch;
          res_o.item.end_of_transfer = 1'b1;
          abort_d                    = !item_i.last_byte;
        end
        pos_d  = '0;
        word_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= CrcInitReset;
      word_q  <= '0;
      abort_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      word_q  <= word_d;
      abort_q <= abort_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(WordBytes))
    else $error("byte position out of range");

  a_abort_at_group_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    abort_q |-> (pos_q == '0) && (word_q == '0))
    else $error("discard state with a partial group");

  a_mismatch_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.item.word_status != StatusOk) |-> res_o.item.end_of_transfer)
    else $error("error result not marked end of transfer");

  a_abort_after_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(abort_q) && abort_q |-> $past(res_o.valid)
      && ($past(res_o.item.word_status) == StatusMismatch))
    else $error("discard entered without a mismatch");

endmodule

// ===== rtl/core/crc8wd_out_stage.sv =====
module crc8wd_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crc8wd_pkg::res_t      res_i,
  output logic                  load_en_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output crc8wd_pkg::out_item_t out_item_o
);
  import crc8wd_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  assign load_en_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_en_o) begin
      valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_o && res_i.valid) begin
      item_q <= res_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ===== rtl/core/crc8_word_deframer.sv =====
// An accepted byte waits in the input register; its result, if it yields one,
// is loaded into the output register once that register can take it.
// Throughput: one byte per cycle unless out_stall_i holds the output; the
// unrolled 8-bit CRC update sits between the input and result registers.
// Reset (rst_ni low, async): pipeline empty, group restarted, discard state
// cleared, polynomial 0x31 and initial value 0xFF.
module crc8_word_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  crc8wd_pkg::in_item_t          in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output crc8wd_pkg::out_item_t         out_item_o,
  input  logic                          cfg_we_i,
  input  logic [crc8wd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                    cfg_wdata_i
);
  import crc8wd_pkg::*;

  cfg_t     cfg_q;
  logic     item_valid;
  in_item_t item;
  logic     load_en;
  logic     fire;
  res_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poly <= CrcPolyReset;
      cfg_q.init <= CrcInitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCrcPoly: cfg_q.poly <= cfg_wdata_i;
        CfgCrcInit: cfg_q.init <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign fire = item_valid && load_en;

  crc8wd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .adv_i        (load_en),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  crc8wd_frame_ctl u_frame_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  crc8wd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .load_en_o   (load_en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== bench/crc8wd_checker.sv =====
package crc8wd_tb_pkg;

  // serial MSB-first CRC-8: each data bit enters at the top of the register
  function automatic logic [7:0] crc8_next(input logic [7:0] crc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

endpackage

module crc8wd_checker
  import crc8wd_pkg::*;
  import crc8wd_tb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_item_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  logic [7:0]       poly_q;
  logic [7:0]       init_q;
  logic [PosW-1:0]  grp_pos;
  logic [7:0]       grp_crc;
  logic [WordW-1:0] grp_word;
  logic             discard_q;
  out_item_t        word_q[$];
  out_item_t        want;
  int               fails;

  task automatic restart_group();
    grp_pos  = '0;
    grp_crc  = init_q;
    grp_word = '0;
  endtask

  // advance the predicted state by one accepted byte, queue the word it yields
  task automatic predict_byte(input in_item_t it);
    out_item_t  res;
    logic [7:0] seed;
    if (discard_q) begin
      if (it.last_byte) begin
        discard_q = 1'b0;
        restart_group();
      end
      return;
    end
    if (grp_pos < WordBytes) begin
      seed     = (grp_pos == 0) ? init_q : grp_crc;
      grp_crc  = crc8_next(seed, it.rx_byte, poly_q);
      grp_word = {grp_word[WordW-9:0], it.rx_byte};
      grp_pos  = grp_pos + 1'b1;
      if (it.last_byte) begin
        res = '{data_word: '0, word_status: StatusTruncated, end_of_transfer: 1'b1};
        word_q.push_back(res);
        restart_group();
      end
    end else begin
      res.data_word = grp_word;
      if (grp_crc == it.rx_byte) begin
        res.word_status     = StatusOk;
        res.end_of_transfer = it.last_byte;
      end else begin
        res.word_status     = StatusMismatch;
        res.end_of_transfer = 1'b1;
        discard_q           = !it.last_byte;
      end
      word_q.push_back(res);
      restart_group();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q    = CrcPolyReset;
      init_q    = CrcInitReset;
      discard_q = 1'b0;
      restart_group();
      word_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (word_q.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual word=%h status=%0d eot=%b",
                   $time, out_item_i.data_word, out_item_i.word_status,
                   out_item_i.end_of_transfer);
          fails++;
        end else begin
          want = word_q.pop_front();
          if (out_item_i.data_word !== want.data_word ||
              out_item_i.word_status !== want.word_status ||
              out_item_i.end_of_transfer !== want.end_of_transfer) begin
            $display("%0t: mismatch: expected %h/%0d/%b, actual %h/%0d/%b",
                     $time, want.data_word, want.word_status, want.end_of_transfer,
                     out_item_i.data_word, out_item_i.word_status,
                     out_item_i.end_of_transfer);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCrcPoly: poly_q = cfg_wdata_i;
          CfgCrcInit: init_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_byte(in_item_i);
      end
    end
    fail_count_o = fails;
    pending_o    = word_q.size();
  end

endmodule

// ===== bench/tb_crc8_word_deframer.sv =====
module tb_crc8_word_deframer;
  import crc8wd_pkg::*;
  import crc8wd_tb_pkg::*;

  localparam int QuietLimit  = 1000;
  localparam int PhaseItems  = 205;
  localparam int PhaseCount  = 8;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_item;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [7:0]         cfg_wdata;

  int         fail_count;
  int         pending;
  int         quiet_cycles;
  int         items_sent;
  bit         calm;   // no idling on either side
  logic [7:0] cur_poly;
  logic [7:0] cur_init;

  crc8_word_deframer DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  crc8wd_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !calm && ($urandom_range(99) < 34);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic l, input bit counted);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{rx_byte: b, last_byte: l};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counted) begin
      items_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_word(input logic [7:0] hi, input logic [7:0] lo,
                           input logic [7:0] bad, input logic l, input bit counted);
    logic [7:0] chk;
    chk = crc8_next(crc8_next(cur_init, hi, cur_poly), lo, cur_poly) ^ bad;
    send_byte(hi, 1'b0, counted);
    send_byte(lo, 1'b0, counted);
    send_byte(chk, l, counted);
  endtask

  // mostly well-formed words; some bad checks, some cut short
  task automatic send_transfer();
    int         nwords;
    int         kind;
    logic [7:0] bad;
    nwords = $urandom_range(1, 5);
    for (int w = 0; w < nwords; w++) begin
      kind = $urandom_range(99);
      if (kind < 6) begin
        if ($urandom_range(1) == 0) begin
          send_byte(8'($urandom), 1'b1, 1'b1);
        end else begin
          send_byte(8'($urandom), 1'b0, 1'b1);
          send_byte(8'($urandom), 1'b1, 1'b1);
        end
        return;
      end
      bad = (kind < 16) ? (8'd1 << $urandom_range(7)) : 8'h00;
      send_word(8'($urandom), 8'($urandom), bad, w == nwords - 1, 1'b1);
    end
  endtask

  // random bytes, the last one always marked last so groups realign
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 7);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom), (i == n - 1) || ($urandom_range(3) == 0), 1'b1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgCrcPoly) begin
      cur_poly = val;
    end else begin
      cur_init = val;
    end
    @(negedge clk);
  endtask

  initial begin
    int         start;
    logic [7:0] p;
    logic [7:0] s;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_we       = 1'b0;
    cfg_idx      = CfgCrcPoly;
    cfg_wdata    = 8'h00;
    calm         = 1'b0;
    items_sent   = 0;
    cur_poly     = CrcPolyReset;
    cur_init     = CrcInitReset;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed, reset settings
    send_word(8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
    send_word(8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1);
    send_word(8'hBE, 8'hEF, 8'h00, 1'b0, 1'b1);
    send_word(8'h12, 8'h34, 8'h80, 1'b0, 1'b1);
    // dropped until the byte marked last
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b1, 1'b0);
    send_byte(8'hA5, 1'b1, 1'b1);
    send_byte(8'h3C, 1'b0, 1'b1);
    send_byte(8'hC3, 1'b1, 1'b1);
    send_word(8'h55, 8'hAA, 8'hFF, 1'b1, 1'b1);
    send_word(8'h01, 8'h80, 8'h00, 1'b1, 1'b1);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain();
      case (ph)
        0: begin p = 8'h00; s = 8'h00; end
        1: begin p = 8'hFF; s = 8'hFF; end
        2: begin p = 8'h07; s = 8'h00; end
        3: begin p = CrcPolyReset; s = CrcInitReset; end
        default: begin p = 8'($urandom); s = 8'($urandom); end
      endcase
      write_reg(CfgCrcPoly, p);
      write_reg(CfgCrcInit, s);
      calm  = (ph == 3);
      start = items_sent;
      while (items_sent - start < PhaseItems) begin
        if ($urandom_range(99) < 85) begin
          send_transfer();
        end else begin
          send_noise();
        end
      end
    end
    calm = 1'b0;
    drain();
    repeat (4) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
